/* sv/gf_polynomial_root_search_defines.svh */
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to be visible in the calling scope.
`ifndef GF_POLYNOMIAL_ROOT_SEARCH_DEFINES_SVH
`define GF_POLYNOMIAL_ROOT_SEARCH_DEFINES_SVH

// Same-cycle implication, checked out of reset only
`define GRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset only
`define GRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/grs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package grs_pkg;

  // Fixed port widths
  localparam int COEFF_W    = 8;
  localparam int ROOT_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int FBITS_W    = 4;
  localparam int FPOLY_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_POLY = 2'd1;

  // Register reset values and the smallest usable field size
  localparam logic [FBITS_W-1:0] FBITS_RST = 4'd8;
  localparam logic [FBITS_W-1:0] FBITS_MIN = 4'd2;
  localparam logic [FPOLY_W-1:0] FPOLY_RST = 8'd29;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_ROOT      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_ROOT   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO_POLY = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_TOO_MANY  = 2'd3;

  // Roots reported per polynomial at most
  localparam int RESULT_CAP = 32;
  localparam int CNT_W      = $clog2(RESULT_CAP + 1);

  // Sequencer states
  typedef enum logic [12:0] {
    ST_CLR      = 13'b0000000000001,
    ST_BLD      = 13'b0000000000010,
    ST_IDLE     = 13'b0000000000100,
    ST_SCAN_RD  = 13'b0000000001000,
    ST_SCAN_CHK = 13'b0000000010000,
    ST_C_RD     = 13'b0000000100000,
    ST_M1_LOG   = 13'b0000001000000,
    ST_M1_ALOG  = 13'b0000010000000,
    ST_M1_ACC   = 13'b0000100000000,
    ST_M2_ALOG  = 13'b0001000000000,
    ST_M2_UPD   = 13'b0010000000000,
    ST_E_END    = 13'b0100000000000,
    ST_FIN      = 13'b1000000000000
  } state_t;

endpackage

`default_nettype wire

/* sv/gf_polynomial_root_search.sv */
// Polynomial root search over GF(2^m).
// Config port: cfg_we/cfg_index/cfg_data write field_bits (index 0) or field_poly
// (index 1). Every such write, and reset, rebuilds the log and antilog tables:
// a log clear sweep over the active field, then a build sweep. in_stall stays
// high during the rebuild.
// Input channel: in_valid/in_stall carry one coefficient per beat, lowest order
// first; in_last_coeff marks the highest-order one. Coefficients load at one
// per cycle while in_stall is low. After the last beat in_stall stays high
// until the final result has been placed in the output register.
// Search: the coefficient scan reads one coefficient after another up to the
// first nonzero one, then each element e = 1 .. 2^m-1 is evaluated in turn,
// stopping at RESULT_CAP roots, by the shared log/antilog table multiplier,
// which forms c_j*e^j and e^(j+1) one after the other. A too-many-coefficients
// status skips the scan; a zero-polynomial status follows it.
// Output channel: out_valid/out_stall; one registered beat per root, or one
// status beat, the final beat flagged by out_last_result. A stall on the
// output holds the search at the next root until the register frees.
// Reset (rst_n low, synchronous) restores the register defaults, drops any
// partial polynomial and clears out_valid.
`timescale 1ns / 1ps
`default_nettype none

module gf_polynomial_root_search #(
  parameter int MAX_DEGREE     = 32,
  parameter int FIELD_MAX_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [grs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [grs_pkg::CFG_DATA_W-1:0]  cfg_data,
  // coefficient input
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [grs_pkg::COEFF_W-1:0]     in_coeff,
  input  wire logic                            in_last_coeff,
  // results
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [grs_pkg::ROOT_W-1:0]           out_root,
  output logic [grs_pkg::STATUS_W-1:0]         out_status,
  output logic                                 out_last_result
);

  localparam int EW          = FIELD_MAX_BITS;
  localparam int TBL_DEPTH   = 1 << FIELD_MAX_BITS;
  localparam int STORE_DEPTH = MAX_DEGREE + 1;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = $clog2(STORE_DEPTH + 1);

  // Storage
  logic [EW-1:0] coef_mem [STORE_DEPTH];
  logic [EW-1:0] log_mem  [TBL_DEPTH];
  logic [EW-1:0] alog_mem [TBL_DEPTH];

  grs_pkg::state_t state_r, state_nxt;

  logic [grs_pkg::FBITS_W-1:0]  fbits_r, fbits_nxt;
  logic [grs_pkg::FPOLY_W-1:0]  fpoly_r, fpoly_nxt;
  logic [EW-1:0]                idx_r, idx_nxt;
  logic [EW-1:0]                v_r, v_nxt;
  logic [CW-1:0]                count_r, count_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [AW-1:0]                j_r, j_nxt;
  logic [EW-1:0]                e_r, e_nxt;
  logic [EW-1:0]                p_r, p_nxt;
  logic [EW-1:0]                sum_r, sum_nxt;
  logic [grs_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                         pend_v_r, pend_v_nxt;
  logic [EW-1:0]                pend_root_r, pend_root_nxt;
  logic [grs_pkg::STATUS_W-1:0] fin_status_r, fin_status_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [grs_pkg::ROOT_W-1:0]   out_root_r, out_root_nxt;
  logic [grs_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                         out_last_r, out_last_nxt;

  // Registered memory reads and multiplier pipeline flags
  logic [EW-1:0] coef_q_r;
  logic [EW-1:0] la_q_r, lb_q_r;
  logic [EW-1:0] alog_q_r;
  logic          zf1_r, zf2_r;

  // Field geometry from the registers
  logic [grs_pkg::FBITS_W-1:0] m_w;
  logic [EW:0]                 size_w;
  logic [EW:0]                 size_m1;
  logic [EW-1:0]               low_w;
  logic [EW-1:0]               top_w;
  logic [EW-1:0]               feed_w;
  logic [EW-1:0]               v_shl;
  logic [EW-1:0]               v_step;

  always_comb begin
    if (fbits_r < grs_pkg::FBITS_MIN) begin
      m_w = grs_pkg::FBITS_MIN;
    end else if (fbits_r > grs_pkg::FBITS_W'(FIELD_MAX_BITS)) begin
      m_w = grs_pkg::FBITS_W'(FIELD_MAX_BITS);
    end else begin
      m_w = fbits_r;
    end
  end

  assign size_w  = {{EW{1'b0}}, 1'b1} << m_w;
  assign size_m1 = size_w - 1'b1;
  assign low_w   = size_m1[EW-1:0];
  assign top_w   = size_w[EW:1];
  assign feed_w  = fpoly_r[EW-1:0] & low_w;

  // LFSR step x*v mod P(x)
  assign v_shl  = {v_r[EW-2:0], 1'b0} & low_w;
  assign v_step = (|(v_r & top_w)) ? (v_shl ^ feed_w) : v_shl;

  // Shared multiplier: log lookup, exponent add mod order, antilog lookup
  logic [EW-1:0] la_addr, lb_addr;
  logic [EW-1:0] coef_m;
  logic [EW:0]   s_sum, ord_x, s_red;
  logic [EW-1:0] smod;
  logic [EW-1:0] mul_res;

  assign coef_m = coef_q_r & low_w;

  always_comb begin
    if (state_r == grs_pkg::ST_M1_LOG) begin
      la_addr = coef_m;
      lb_addr = p_r;
    end else begin
      la_addr = p_r;
      lb_addr = e_r;
    end
  end

  assign s_sum   = {1'b0, la_q_r} + {1'b0, lb_q_r};
  assign ord_x   = {1'b0, low_w};
  assign s_red   = (s_sum >= ord_x) ? (s_sum - ord_x) : s_sum;
  assign smod    = (s_red == ord_x) ? '0 : s_red[EW-1:0];
  assign mul_res = zf2_r ? '0 : alog_q_r;

  // Handshake terms
  logic cfg_hit, in_acc, out_free;

  assign cfg_hit  = cfg_we && ((cfg_index == grs_pkg::CFG_FIELD_BITS) ||
                               (cfg_index == grs_pkg::CFG_FIELD_POLY));
  assign in_stall = (state_r != grs_pkg::ST_IDLE) || cfg_hit;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Memory write controls
  logic          coef_we;
  logic          log_we;
  logic [EW-1:0] log_waddr, log_wdata;
  logic          alog_we;
  logic          out_load;
  logic          j_last;
  logic          ovf_hit;

  assign j_last  = (CW'(j_r) + CW'(1)) == count_r;
  assign ovf_hit = ovf_r || (count_r == CW'(STORE_DEPTH));

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    fbits_nxt      = fbits_r;
    fpoly_nxt      = fpoly_r;
    idx_nxt        = idx_r;
    v_nxt          = v_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    j_nxt          = j_r;
    e_nxt          = e_r;
    p_nxt          = p_r;
    sum_nxt        = sum_r;
    cnt_nxt        = cnt_r;
    pend_v_nxt     = pend_v_r;
    pend_root_nxt  = pend_root_r;
    fin_status_nxt = fin_status_r;
    coef_we        = 1'b0;
    log_we         = 1'b0;
    log_waddr      = idx_r;
    log_wdata      = '0;
    alog_we        = 1'b0;
    out_load       = 1'b0;
    out_root_nxt   = out_root_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      // clear the log table over the active field
      grs_pkg::ST_CLR: begin
        log_we = 1'b1;
        if (idx_r == low_w) begin
          idx_nxt   = '0;
          v_nxt     = {{(EW-1){1'b0}}, 1'b1};
          state_nxt = grs_pkg::ST_BLD;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // antilog[i] = v, log[v] = i
      grs_pkg::ST_BLD: begin
        alog_we   = 1'b1;
        log_we    = 1'b1;
        log_waddr = v_r;
        log_wdata = idx_r;
        v_nxt     = v_step;
        if (idx_r == low_w) begin
          state_nxt = grs_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // load coefficients
      grs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (count_r < CW'(STORE_DEPTH)) begin
            coef_we   = 1'b1;
            count_nxt = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_coeff) begin
            if (ovf_hit) begin
              fin_status_nxt = grs_pkg::STAT_TOO_MANY;
              pend_v_nxt     = 1'b0;
              state_nxt      = grs_pkg::ST_FIN;
            end else begin
              j_nxt     = '0;
              state_nxt = grs_pkg::ST_SCAN_RD;
            end
          end
        end
      end

      grs_pkg::ST_SCAN_RD: begin
        state_nxt = grs_pkg::ST_SCAN_CHK;
      end

      // look for any nonzero coefficient
      grs_pkg::ST_SCAN_CHK: begin
        if (coef_m != '0) begin
          e_nxt          = {{(EW-1){1'b0}}, 1'b1};
          p_nxt          = {{(EW-1){1'b0}}, 1'b1};
          sum_nxt        = '0;
          j_nxt          = '0;
          cnt_nxt        = '0;
          pend_v_nxt     = 1'b0;
          fin_status_nxt = grs_pkg::STAT_NO_ROOT;
          state_nxt      = grs_pkg::ST_C_RD;
        end else if (j_last) begin
          fin_status_nxt = grs_pkg::STAT_ZERO_POLY;
          pend_v_nxt     = 1'b0;
          state_nxt      = grs_pkg::ST_FIN;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = grs_pkg::ST_SCAN_RD;
        end
      end

      grs_pkg::ST_C_RD: begin
        state_nxt = grs_pkg::ST_M1_LOG;
      end

      grs_pkg::ST_M1_LOG: begin
        state_nxt = grs_pkg::ST_M1_ALOG;
      end

      grs_pkg::ST_M1_ALOG: begin
        state_nxt = grs_pkg::ST_M1_ACC;
      end

      // accumulate c_j * p, issue p * e
      grs_pkg::ST_M1_ACC: begin
        sum_nxt   = sum_r ^ mul_res;
        state_nxt = grs_pkg::ST_M2_ALOG;
      end

      grs_pkg::ST_M2_ALOG: begin
        state_nxt = grs_pkg::ST_M2_UPD;
      end

      grs_pkg::ST_M2_UPD: begin
        p_nxt = mul_res;
        if (j_last) begin
          state_nxt = grs_pkg::ST_E_END;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = grs_pkg::ST_C_RD;
        end
      end

      // one element done; the previous root leaves once a newer one is found
      grs_pkg::ST_E_END: begin
        if (!((sum_r == '0) && pend_v_r && !out_free)) begin
          if (sum_r == '0) begin
            if (pend_v_r) begin
              out_load       = 1'b1;
              out_root_nxt   = grs_pkg::ROOT_W'(pend_root_r);
              out_status_nxt = grs_pkg::STAT_ROOT;
              out_last_nxt   = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_root_nxt = e_r;
            cnt_nxt       = cnt_r + 1'b1;
          end
          if (((sum_r == '0) && (cnt_r == grs_pkg::CNT_W'(grs_pkg::RESULT_CAP - 1))) ||
              (e_r == low_w)) begin
            state_nxt = grs_pkg::ST_FIN;
          end else begin
            e_nxt     = e_r + 1'b1;
            p_nxt     = {{(EW-1){1'b0}}, 1'b1};
            sum_nxt   = '0;
            j_nxt     = '0;
            state_nxt = grs_pkg::ST_C_RD;
          end
        end
      end

      // final beat, then ready for the next polynomial
      grs_pkg::ST_FIN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_last_nxt = 1'b1;
          if (pend_v_r) begin
            out_root_nxt   = grs_pkg::ROOT_W'(pend_root_r);
            out_status_nxt = grs_pkg::STAT_ROOT;
          end else begin
            out_root_nxt   = '0;
            out_status_nxt = fin_status_r;
          end
          pend_v_nxt = 1'b0;
          count_nxt  = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = grs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = grs_pkg::ST_CLR;
        idx_nxt   = '0;
      end
    endcase

    // register write restarts the table build
    if (cfg_hit) begin
      if (cfg_index == grs_pkg::CFG_FIELD_BITS) begin
        fbits_nxt = cfg_data[grs_pkg::FBITS_W-1:0];
      end else begin
        fpoly_nxt = cfg_data[grs_pkg::FPOLY_W-1:0];
      end
      idx_nxt   = '0;
      state_nxt = grs_pkg::ST_CLR;
    end

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grs_pkg::ST_CLR;
      fbits_r     <= grs_pkg::FBITS_RST;
      fpoly_r     <= grs_pkg::FPOLY_RST;
      idx_r       <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fbits_r     <= fbits_nxt;
      fpoly_r     <= fpoly_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    v_r          <= v_nxt;
    j_r          <= j_nxt;
    e_r          <= e_nxt;
    p_r          <= p_nxt;
    sum_r        <= sum_nxt;
    cnt_r        <= cnt_nxt;
    pend_root_r  <= pend_root_nxt;
    fin_status_r <= fin_status_nxt;
    out_root_r   <= out_root_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
    zf1_r        <= (la_addr == '0) || (lb_addr == '0);
    zf2_r        <= zf1_r;
  end

  // Coefficient store
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[count_r[AW-1:0]] <= in_coeff[EW-1:0] & low_w;
    end
    coef_q_r <= coef_mem[j_r];
  end

  // Log table: one write port, two read ports
  always_ff @(posedge clk) begin
    if (log_we) begin
      log_mem[log_waddr] <= log_wdata;
    end
    la_q_r <= log_mem[la_addr];
    lb_q_r <= log_mem[lb_addr];
  end

  // Antilog table
  always_ff @(posedge clk) begin
    if (alog_we) begin
      alog_mem[idx_r] <= v_r;
    end
    alog_q_r <= alog_mem[smod];
  end

  assign out_valid       = out_valid_r;
  assign out_root        = out_root_r;
  assign out_status      = out_status_r;
  assign out_last_result = out_last_r;

endmodule

`default_nettype wire

/* sv/grs_chk.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "gf_polynomial_root_search_defines.svh"

module grs_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [grs_pkg::ROOT_W-1:0]     out_root,
  input wire logic [grs_pkg::STATUS_W-1:0]   out_status,
  input wire logic                           out_last_result
);

  // status beats close a polynomial and carry no root
  `GRS_ASSERT_IMP(a_status_is_last, out_valid && (out_status != grs_pkg::STAT_ROOT), out_last_result, "status beat without last flag")
  `GRS_ASSERT_IMP(a_status_no_root, out_valid && (out_status != grs_pkg::STAT_ROOT), out_root == '0, "status beat with nonzero root")
  // zero is never a searched element
  `GRS_ASSERT_IMP(a_root_nonzero, out_valid && (out_status == grs_pkg::STAT_ROOT), out_root != '0, "zero reported as root")
  // tables are rebuilt straight after reset
  `GRS_ASSERT_IMP(a_busy_after_reset, $past(!rst_n), in_stall, "input open before table build")
  // stalled result beat holds
  `GRS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_root) && $stable(out_status) && $stable(out_last_result), "stalled result changed")

endmodule

bind gf_polynomial_root_search grs_chk u_grs_chk (.*);

`default_nettype wire

/* test/gf_polynomial_root_search_tb.sv */
`timescale 1ns / 1ps

module gf_polynomial_root_search_tb;

  localparam int STORE_DEPTH = 33;
  localparam int N_ITEMS     = 110;
  // feedback taps of a primitive polynomial for each field size
  localparam logic [7:0] PRIM_FEED [9] = '{8'd0, 8'd0, 8'd3, 8'd3, 8'd3, 8'd5, 8'd3, 8'd3,
                                          8'd29};

  typedef struct packed {
    logic [grs_pkg::ROOT_W-1:0]   root;
    logic [grs_pkg::STATUS_W-1:0] status;
    logic                         last;
  } report_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [grs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [grs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [grs_pkg::COEFF_W-1:0]    in_coeff = '0;
  logic                           in_last_coeff = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [grs_pkg::ROOT_W-1:0]     out_root;
  logic [grs_pkg::STATUS_W-1:0]   out_status;
  logic                           out_last_result;

  gf_polynomial_root_search dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_coeff        (in_coeff),
    .in_last_coeff   (in_last_coeff),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_root        (out_root),
    .out_status      (out_status),
    .out_last_result (out_last_result)
  );

  always #1 clk = ~clk;

  // field model: registers, tables and coefficient store
  logic [grs_pkg::FBITS_W-1:0] bits_reg;
  logic [grs_pkg::FPOLY_W-1:0] poly_reg;
  logic [7:0]         alog_tab [256];
  logic [7:0]         log_tab [256];
  logic [7:0]         coef_mem [STORE_DEPTH];
  int                 coef_cnt;
  bit                 overflowed;

  report_t            roots_due[$];
  logic [7:0]         coeff_list[$];
  int                 fail_count = 0;
  int                 gap_max = 16;
  int                 sent_count = 0;
  int                 rx_wait = 0;

  function automatic int field_m();
    int m = bits_reg;
    if (m < 2) m = 2;
    if (m > 8) m = 8;
    return m;
  endfunction

  // shift register x^i mod P(x); log entry keeps the last index that hit it
  function automatic void build_tables();
    int m, size, low, top, feed, v;
    m = field_m();
    size = 1 << m;
    low = size - 1;
    top = 1 << (m - 1);
    feed = poly_reg & low;
    v = 1;
    for (int i = 0; i < 256; i++) begin
      alog_tab[i] = '0;
      log_tab[i] = '0;
    end
    for (int i = 0; i < size; i++) begin
      alog_tab[i] = 8'(v);
      log_tab[v & 255] = 8'(i);
      v = (v & top) ? (((v << 1) & low) ^ feed) : ((v << 1) & low);
    end
    log_tab[0] = '0;
  endfunction

  function automatic int gf_times(int a, int b, int order);
    int s;
    a &= 255;
    b &= 255;
    if (a == 0 || b == 0) return 0;
    s = int'(log_tab[a]) + int'(log_tab[b]);
    if (s >= order) s %= order;
    return int'(alog_tab[s & 255]);
  endfunction

  function automatic void field_reset();
    bits_reg = grs_pkg::FBITS_RST;
    poly_reg = grs_pkg::FPOLY_RST;
    build_tables();
    for (int j = 0; j < STORE_DEPTH; j++) coef_mem[j] = '0;
    coef_cnt = 0;
    overflowed = 1'b0;
  endfunction

  // append one report to the queue of reports due
  function automatic void due_add(logic [7:0] root, logic [1:0] status, logic lst);
    report_t r;
    r.root = root;
    r.status = status;
    r.last = lst;
    roots_due.insert(roots_due.size(), r);
  endfunction

  // store one coefficient; on the last one, search the nonzero elements up to the report cap
  function automatic void take_coeff(logic [7:0] c_in, logic lst);
    int m, low, n, cnt, sum, p;
    bit nonzero;
    m = field_m();
    low = (1 << m) - 1;
    if (coef_cnt < STORE_DEPTH) begin
      coef_mem[coef_cnt] = c_in & 8'(low);
      coef_cnt++;
    end else begin
      overflowed = 1'b1;
    end
    if (!lst) return;
    n = coef_cnt;
    cnt = 0;
    nonzero = 1'b0;
    if (overflowed) begin
      due_add('0, grs_pkg::STAT_TOO_MANY, 1'b1);
    end else begin
      for (int j = 0; j < n; j++)
        if ((coef_mem[j] & low) != 0) nonzero = 1'b1;
      if (!nonzero) begin
        due_add('0, grs_pkg::STAT_ZERO_POLY, 1'b1);
      end else begin
        for (int e = 1; e <= low && cnt < grs_pkg::RESULT_CAP; e++) begin
          sum = 0;
          p = 1;
          for (int j = 0; j < n; j++) begin
            sum ^= gf_times(coef_mem[j] & low, p, low);
            p = gf_times(p, e, low);
          end
          if (sum == 0) begin
            due_add(8'(e), grs_pkg::STAT_ROOT, 1'b0);
            cnt++;
          end
        end
        if (cnt > 0) begin
          roots_due[roots_due.size() - 1].last = 1'b1;
        end else begin
          due_add('0, grs_pkg::STAT_NO_ROOT, 1'b1);
        end
      end
    end
    coef_cnt = 0;
    overflowed = 1'b0;
  endfunction

  // result side: random stall per beat, then compare with the oldest report due
  always @(posedge clk) begin
    report_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (roots_due.size() == 0) begin
        $error("unexpected beat: root %0d status %0d last %0d",
               out_root, out_status, out_last_result);
        fail_count++;
      end else begin
        want = roots_due.pop_front();
        if (out_root !== want.root) begin
          $error("root: expected %0d, got %0d", want.root, out_root);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          fail_count++;
        end
        if (out_last_result !== want.last) begin
          $error("last_result: expected %0d, got %0d", want.last, out_last_result);
          fail_count++;
        end
      end
      rx_wait = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    end
    if (rx_wait > 0) begin
      out_stall <= 1'b1;
      rx_wait--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one coefficient beat; valid stays high afterwards unless a gap follows
  task automatic send_coeff(input logic [7:0] c, input logic lst);
    int gap;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_coeff      <= c;
    in_last_coeff <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    take_coeff(c, lst);
    sent_count++;
  endtask

  task automatic send_poly();
    foreach (coeff_list[i]) send_coeff(coeff_list[i], i == coeff_list.size() - 1);
  endtask

  // drop valid and let every report due drain out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (roots_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [grs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [grs_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == grs_pkg::CFG_FIELD_BITS) bits_reg = val[grs_pkg::FBITS_W-1:0];
    else if (idx == grs_pkg::CFG_FIELD_POLY) poly_reg = val;
    build_tables();
    // table rebuild holds the input stalled
    repeat (2) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_field(input int fb, input int fp);
    wait_idle();
    write_reg(grs_pkg::CFG_FIELD_BITS, {4'($urandom), 4'(fb)});
    write_reg(grs_pkg::CFG_FIELD_POLY, 8'(fp));
  endtask

  // reset field GF(256): single roots, top element, zero and constant polys
  task automatic test_default_field();
    gap_max = 0;
    coeff_list = '{8'd2, 8'd1};
    send_poly();
    coeff_list = '{8'hFF, 8'h01};
    send_poly();
    coeff_list = '{8'd0};
    send_poly();
    coeff_list = '{8'd7};
    send_poly();
    gap_max = 16;
    coeff_list = '{8'd0, 8'd0, 8'h80};
    send_poly();
  endtask

  // GF(4): two roots, and coefficients that mask down to nothing
  task automatic test_small_field();
    set_field(2, 3);
    coeff_list = '{8'hFD, 8'hFD, 8'hFD};
    send_poly();
    coeff_list = '{8'hFC, 8'h04};
    send_poly();
  endtask

  // field sizes outside 2..8 and polynomials that are not primitive
  task automatic test_clamped_sizes();
    set_field(0, 3);
    coeff_list = '{8'd3, 8'd1};
    send_poly();
    // feedback of zero: most elements look like roots, report cap applies
    set_field(15, 0);
    coeff_list = '{8'd1, 8'd1};
    send_poly();
    set_field(1, 8'hFF);
    coeff_list = '{8'd2, 8'd0, 8'd1};
    send_poly();
    set_field(9, 8'hFF);
    coeff_list = '{8'h33, 8'h01};
    send_poly();
  endtask

  // field change with a partial polynomial held in the store
  task automatic test_change_mid_poly();
    set_field(8, 29);
    gap_max = 0;
    send_coeff(8'hFF, 1'b0);
    send_coeff(8'hF0, 1'b0);
    wait_idle();
    write_reg(grs_pkg::CFG_FIELD_BITS, 8'd3);
    write_reg(grs_pkg::CFG_FIELD_POLY, 8'd3);
    send_coeff(8'h01, 1'b1);
    gap_max = 16;
  endtask

  // a full store, then one to three coefficients too many
  task automatic test_store_limits();
    set_field(3, 3);
    coeff_list = {};
    repeat (STORE_DEPTH) coeff_list.insert(coeff_list.size(), 8'($urandom));
    send_poly();
    coeff_list = {};
    repeat (STORE_DEPTH + $urandom_range(1, 3))
      coeff_list.insert(coeff_list.size(), 8'($urandom));
    send_poly();
  endtask

  // random fields and polynomials; short ones where the field is large
  task automatic test_random();
    int fb, m, len;
    bit zero_poly;
    while (sent_count < N_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 9))
          0: fb = $urandom_range(0, 1);
          1: fb = $urandom_range(8, 15);
          default: fb = $urandom_range(2, 7);
        endcase
        m = (fb < 2) ? 2 : (fb > 8) ? 8 : fb;
        set_field(fb, $urandom_range(0, 1) ? int'(PRIM_FEED[m]) : $urandom_range(0, 255));
      end else if ($urandom_range(0, 7) == 0) begin
        wait_idle();
      end
      gap_max = ($urandom_range(0, 3) == 0) ? 0 : 16;
      m = field_m();
      len = (m == 8) ? $urandom_range(1, 4) : $urandom_range(1, 6);
      zero_poly = ($urandom_range(0, 5) == 0);
      coeff_list = {};
      repeat (len)
        coeff_list.insert(coeff_list.size(),
                          zero_poly ? 8'($urandom) & ~8'((1 << m) - 1) : 8'($urandom));
      send_poly();
    end
  endtask

  initial begin
    field_reset();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_default_field();
    test_small_field();
    test_clamped_sizes();
    test_change_mid_poly();
    test_store_limits();
    test_random();
    wait_idle();
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("gf_polynomial_root_search_tb: done, clean");
    else $display("gf_polynomial_root_search_tb: done, errors");
    $finish;
  end

  // hang guard
  initial begin
    #4_000_000;
    $display("gf_polynomial_root_search_tb: done, errors");
    $finish;
  end

endmodule

/* gf_polynomial_root_search.f */
+incdir+sv
sv/grs_pkg.sv
sv/gf_polynomial_root_search.sv
sv/grs_chk.sv
test/gf_polynomial_root_search_tb.sv
